[src/tard_pkg.sv]
package tard_pkg;

    // Control codes, column 0x00-0x1f
    localparam logic [6:0] CODE_ALPHA_BLACK   = 7'h00;
    localparam logic [6:0] CODE_ALPHA_WHITE   = 7'h07;
    localparam logic [6:0] CODE_FLASH         = 7'h08;
    localparam logic [6:0] CODE_STEADY        = 7'h09;
    localparam logic [6:0] CODE_END_BOX       = 7'h0a;
    localparam logic [6:0] CODE_START_BOX     = 7'h0b;
    localparam logic [6:0] CODE_NORMAL_SIZE   = 7'h0c;
    localparam logic [6:0] CODE_DOUBLE_HEIGHT = 7'h0d;
    localparam logic [6:0] CODE_MOSAIC_BLACK  = 7'h10;
    localparam logic [6:0] CODE_MOSAIC_WHITE  = 7'h17;
    localparam logic [6:0] CODE_CONCEAL       = 7'h18;
    localparam logic [6:0] CODE_CONTIGUOUS    = 7'h19;
    localparam logic [6:0] CODE_SEPARATED     = 7'h1a;
    localparam logic [6:0] CODE_BLACK_BG      = 7'h1c;
    localparam logic [6:0] CODE_NEW_BG        = 7'h1d;
    localparam logic [6:0] CODE_HOLD          = 7'h1e;
    localparam logic [6:0] CODE_RELEASE       = 7'h1f;
    localparam logic [6:0] CODE_SPACE         = 7'h20;

    localparam logic [2:0] COLOUR_WHITE       = 3'd7;
    localparam logic [3:0] COLOUR_BLACK       = 4'd0;
    localparam logic [3:0] COLOUR_TRANSPARENT = 4'd8;

    // Configuration register indexes
    localparam logic [1:0] CFG_MIX_MODE       = 2'd0;
    localparam logic [1:0] CFG_FLASH_PHASE_ON = 2'd1;
    localparam logic [1:0] CFG_REVEAL         = 2'd2;

    typedef struct packed {
        logic mix_mode;
        logic flash_phase_on;
        logic reveal;
    } t_cfg;

    typedef struct packed {
        logic       default_transparent;
        logic       first_in_row;
        logic [6:0] char_code;
    } t_item;

    typedef struct packed {
        logic       mosaic_mode;
        logic       hold;
        logic       separated;
        logic       box;
        logic       flash;
        logic       double_height;
        logic       conceal;
    } t_flags;

    typedef struct packed {
        logic [2:0] fg_colour;
        logic [3:0] bg_colour;
        logic       row_default_bg;
        t_flags     flags;
        logic [6:0] held_mosaic;
    } t_attr;

    typedef struct packed {
        logic       glyph_visible;
        logic       double_height;
        logic       concealed;
        logic       flashing;
        logic       separated;
        logic       mosaic;
        logic [6:0] glyph;
        logic [3:0] background;
        logic [2:0] foreground;
    } t_result;

    localparam t_attr ATTR_RESET = '{
        fg_colour:      COLOUR_WHITE,
        bg_colour:      COLOUR_BLACK,
        row_default_bg: 1'b0,
        flags:          '0,
        held_mosaic:    CODE_SPACE
    };

endpackage

[src/tard_in_stage.sv]
module tard_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tard_pkg::t_item     i_item,
    input  logic                i_advance,
    output logic                o_valid,
    output tard_pkg::t_item     o_item
);
    import tard_pkg::*;

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

[src/tard_decode.sv]
module tard_decode (
    input  tard_pkg::t_cfg      i_cfg,
    input  tard_pkg::t_attr     i_attr,
    input  tard_pkg::t_item     i_item,
    output tard_pkg::t_attr     o_attr,
    output tard_pkg::t_result   o_result
);
    import tard_pkg::*;

    t_attr      a;
    logic [6:0] c;
    logic [6:0] ch;
    logic [3:0] dflt_bg;
    logic       hidden;
    logic       is_mosaic;

    always_comb begin
        a = i_attr;
        c = i_item.char_code;

        if (i_item.first_in_row) begin
            a.row_default_bg = i_item.default_transparent;
            a.fg_colour      = COLOUR_WHITE;
            a.flags          = '0;
            a.bg_colour      = i_item.default_transparent ? COLOUR_TRANSPARENT : COLOUR_BLACK;
            a.held_mosaic    = CODE_SPACE;
        end

        dflt_bg = a.row_default_bg ? COLOUR_TRANSPARENT : COLOUR_BLACK;
        ch      = c;

        if (c < CODE_SPACE) begin
            case (c) inside
                [CODE_ALPHA_BLACK:CODE_ALPHA_WHITE]: begin
                    a.fg_colour         = c[2:0];
                    a.flags.mosaic_mode = 1'b0;
                    a.flags.conceal     = 1'b0;
                end
                [CODE_MOSAIC_BLACK:CODE_MOSAIC_WHITE]: begin
                    a.fg_colour         = c[2:0];
                    a.flags.mosaic_mode = 1'b1;
                end
                CODE_FLASH:         a.flags.flash = 1'b1;
                CODE_STEADY:        a.flags.flash = 1'b0;
                CODE_END_BOX: begin
                    a.bg_colour = dflt_bg;
                    a.flags.box = 1'b0;
                end
                CODE_START_BOX: begin
                    a.bg_colour = COLOUR_BLACK;
                    a.flags.box = 1'b1;
                end
                CODE_NORMAL_SIZE:   a.flags.double_height = 1'b0;
                CODE_DOUBLE_HEIGHT: a.flags.double_height = 1'b1;
                CODE_CONCEAL:       a.flags.conceal = 1'b1;
                CODE_CONTIGUOUS:    a.flags.separated = 1'b0;
                CODE_SEPARATED:     a.flags.separated = 1'b1;
                CODE_BLACK_BG:      a.bg_colour = a.flags.box ? COLOUR_BLACK : dflt_bg;
                CODE_NEW_BG: begin
                    if (!i_cfg.mix_mode) begin
                        a.bg_colour = {1'b0, a.fg_colour};
                    end
                end
                CODE_HOLD:          a.flags.hold = 1'b1;
                CODE_RELEASE:       a.flags.hold = 1'b0;
                default: ;
            endcase
            // control cells show a space, or the held mosaic under hold
            ch = a.flags.hold ? a.held_mosaic : CODE_SPACE;
        end

        hidden = (a.flags.flash && !i_cfg.flash_phase_on) ||
                 (a.flags.conceal && !i_cfg.reveal);
        is_mosaic = a.flags.mosaic_mode && ch[5];

        if (is_mosaic) begin
            a.held_mosaic = ch;
        end

        o_attr = a;

        o_result.foreground    = a.fg_colour;
        o_result.background    = a.bg_colour;
        o_result.glyph         = is_mosaic ? {1'b0, ch[6], ch[4:0]} : ch;
        o_result.mosaic        = is_mosaic;
        o_result.separated     = a.flags.separated;
        o_result.flashing      = a.flags.flash;
        o_result.concealed     = a.flags.conceal;
        o_result.double_height = a.flags.double_height;
        o_result.glyph_visible = !hidden && (is_mosaic || ch != CODE_SPACE);
    end

endmodule

[src/teletext_row_attribute_decoder.sv]
// Level 1 teletext serial attribute decoder for one display row. Feed one
// 7-bit character per column on the slave stream, with tuser bit 0 set on
// column 0 so the row attributes restart from their defaults. Each item
// yields exactly one result: colours, glyph or mosaic pattern, attribute
// flags and a draw flag for the current flash phase and reveal setting.
// An item passes an input register and one decode step into the output
// register, and one item is taken every cycle while the master side keeps
// up; the attribute state updates once per item as it moves into the
// output register. Write configuration only while no item is in flight.
module teletext_row_attribute_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [0:0]  i_cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [6:0] char_code, [7] zero
    input  logic [1:0]  s_tuser,   // [0] first_in_row, [1] default_transparent
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] foreground, [6:3] background, [13:7] glyph,
                                   // [14] separated, [15] flashing, [16] concealed,
                                   // [17] double_height, [18] glyph_visible, [23:19] zero
    output logic [0:0]  m_tuser    // [0] mosaic
);
    import tard_pkg::*;

    t_cfg    r_cfg;
    t_attr   r_attr;
    t_attr   n_attr;
    t_item   s_item;
    t_item   q_item;
    t_result n_result;
    t_result r_result;
    logic    r_out_valid;
    logic    q_valid;
    logic    advance;

    assign s_item = '{default_transparent: s_tuser[1], first_in_row: s_tuser[0],
                      char_code: s_tdata[6:0]};

    assign advance = q_valid && (!r_out_valid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{mix_mode: 1'b0, flash_phase_on: 1'b1, reveal: 1'b0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIX_MODE:       r_cfg.mix_mode       <= i_cfg_data[0];
                CFG_FLASH_PHASE_ON: r_cfg.flash_phase_on <= i_cfg_data[0];
                CFG_REVEAL:         r_cfg.reveal         <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tard_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_tvalid),
        .o_ready   (s_tready),
        .i_item    (s_item),
        .i_advance (advance),
        .o_valid   (q_valid),
        .o_item    (q_item)
    );

    tard_decode u_decode (
        .i_cfg    (r_cfg),
        .i_attr   (r_attr),
        .i_item   (q_item),
        .o_attr   (n_attr),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr      <= ATTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_attr <= n_attr;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'd0, r_result.glyph_visible, r_result.double_height,
                       r_result.concealed, r_result.flashing, r_result.separated,
                       r_result.glyph, r_result.background, r_result.foreground};
    assign m_tuser  = r_result.mosaic;

    // a mosaic pattern only ever uses six bits
    a_mosaic_six_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[13] == 1'b0))
        else $error("mosaic glyph has bit 6 set");

    a_bg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[6:3] <= COLOUR_TRANSPARENT))
        else $error("background colour out of range");

    // a held input item must move on when the output register is free
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !r_out_valid) |=> r_out_valid)
        else $error("item stuck in input register");

    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && q_item.first_in_row) |=>
            (r_attr.row_default_bg == $past(q_item.default_transparent)))
        else $error("row default background not taken at row start");

endmodule

[tb/tb_teletext_row_attribute_decoder.sv]
`timescale 1ns / 1ps

module tb_teletext_row_attribute_decoder;
    import tard_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 220;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 4;

    // Control codes with no effect on the attributes
    localparam logic [6:0] CODE_UNUSED_0E = 7'h0e;
    localparam logic [6:0] CODE_UNUSED_0F = 7'h0f;
    localparam logic [6:0] CODE_UNUSED_1B = 7'h1b;

    typedef struct packed {
        logic [6:0] code;
        logic       first;
        logic       dflt_transp;
        logic       pinned;
        t_result    want;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = '0;
    logic [0:0]  i_cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [6:0] char_code, [7] zero
    logic [1:0]  s_tuser = '0;     // [0] first_in_row, [1] default_transparent
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [2:0] foreground, [6:3] background, [13:7] glyph,
                                   // [14] separated, [15] flashing, [16] concealed,
                                   // [17] double_height, [18] glyph_visible
    logic [0:0]  m_tuser;          // [0] mosaic

    teletext_row_attribute_decoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Decoder mirror: attribute state of the current row and register copy
    t_attr   row_attr = ATTR_RESET;
    t_cfg    cfg_now = 3'b010;
    t_result cell_q[$];
    int      errors = 0;
    int      cycles = 0;

    // Directed-part pinning, driven along with the item
    logic    pin_flag = 1'b0;
    t_result pin_val = '0;

    int      burst_left = 0;
    int      hold_asked = 0;
    int      hold_taken = 0;
    int      hold_left = 0;
    int      rx_window = 0;
    int      rx_mode = 0;
    int      rx_tick = 0;
    logic [15:0] stall_mask = '1;

    t_dir_row dir_rows[$];

    function automatic logic [3:0] row_bg();
        return row_attr.row_default_bg ? COLOUR_TRANSPARENT : COLOUR_BLACK;
    endfunction

    function automatic t_result decode_cell(logic [6:0] code, logic first, logic dflt_transp);
        t_result r;
        logic [6:0] ch;
        logic hidden;
        r = '0;
        if (first) begin
            row_attr.row_default_bg = dflt_transp;
            row_attr.fg_colour = COLOUR_WHITE;
            row_attr.flags = '0;
            row_attr.bg_colour = row_bg();
            row_attr.held_mosaic = CODE_SPACE;
        end
        ch = code;
        if (code < CODE_SPACE) begin
            if (code <= CODE_ALPHA_WHITE) begin
                row_attr.fg_colour = code[2:0];
                row_attr.flags.mosaic_mode = 1'b0;
                row_attr.flags.conceal = 1'b0;
            end else if (code >= CODE_MOSAIC_BLACK && code <= CODE_MOSAIC_WHITE) begin
                row_attr.fg_colour = code[2:0];
                row_attr.flags.mosaic_mode = 1'b1;
            end else begin
                case (code)
                    CODE_FLASH:         row_attr.flags.flash = 1'b1;
                    CODE_STEADY:        row_attr.flags.flash = 1'b0;
                    CODE_END_BOX: begin
                        row_attr.bg_colour = row_bg();
                        row_attr.flags.box = 1'b0;
                    end
                    CODE_START_BOX: begin
                        row_attr.bg_colour = COLOUR_BLACK;
                        row_attr.flags.box = 1'b1;
                    end
                    CODE_NORMAL_SIZE:   row_attr.flags.double_height = 1'b0;
                    CODE_DOUBLE_HEIGHT: row_attr.flags.double_height = 1'b1;
                    CODE_CONCEAL:       row_attr.flags.conceal = 1'b1;
                    CODE_CONTIGUOUS:    row_attr.flags.separated = 1'b0;
                    CODE_SEPARATED:     row_attr.flags.separated = 1'b1;
                    CODE_BLACK_BG:
                        row_attr.bg_colour = row_attr.flags.box ? COLOUR_BLACK : row_bg();
                    CODE_NEW_BG:
                        if (!cfg_now.mix_mode) row_attr.bg_colour = {1'b0, row_attr.fg_colour};
                    CODE_HOLD:          row_attr.flags.hold = 1'b1;
                    CODE_RELEASE:       row_attr.flags.hold = 1'b0;
                    default: ;
                endcase
            end
            // control cells show a space, or the held mosaic while hold is on
            ch = row_attr.flags.hold ? row_attr.held_mosaic : CODE_SPACE;
        end
        hidden = (row_attr.flags.flash && !cfg_now.flash_phase_on) ||
                 (row_attr.flags.conceal && !cfg_now.reveal);
        if (row_attr.flags.mosaic_mode && ch[5]) begin
            row_attr.held_mosaic = ch;
            r.glyph = {1'b0, ch[6], ch[4:0]};
            r.mosaic = 1'b1;
            r.glyph_visible = !hidden;
        end else begin
            r.glyph = ch;
            r.mosaic = 1'b0;
            r.glyph_visible = !hidden && ch != CODE_SPACE;
        end
        r.foreground = row_attr.fg_colour;
        r.background = row_attr.bg_colour;
        r.separated = row_attr.flags.separated;
        r.flashing = row_attr.flags.flash;
        r.concealed = row_attr.flags.conceal;
        r.double_height = row_attr.flags.double_height;
        return r;
    endfunction

    function automatic t_result plain_cell(logic [2:0] fg, logic [3:0] bg, logic [6:0] glyph,
                                           logic vis);
        t_result r;
        r = '0;
        r.foreground = fg;
        r.background = bg;
        r.glyph = glyph;
        r.glyph_visible = vis;
        return r;
    endfunction

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_result want;
        t_result got;
        if (i_rst_n && m_tvalid && m_tready) begin
            got.foreground = m_tdata[2:0];
            got.background = m_tdata[6:3];
            got.glyph = m_tdata[13:7];
            got.separated = m_tdata[14];
            got.flashing = m_tdata[15];
            got.concealed = m_tdata[16];
            got.double_height = m_tdata[17];
            got.glyph_visible = m_tdata[18];
            got.mosaic = m_tuser[0];
            if (cell_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h/%h", $time,
                         m_tdata, m_tuser);
                errors++;
            end else begin
                want = cell_q.pop_front();
                check_field("foreground", want.foreground, got.foreground);
                check_field("background", want.background, got.background);
                check_field("glyph", want.glyph, got.glyph);
                check_field("mosaic", want.mosaic, got.mosaic);
                check_field("separated", want.separated, got.separated);
                check_field("flashing", want.flashing, got.flashing);
                check_field("concealed", want.concealed, got.concealed);
                check_field("double_height", want.double_height, got.double_height);
                check_field("glyph_visible", want.glyph_visible, got.glyph_visible);
            end
        end
        if (i_rst_n && s_tvalid && s_tready) begin
            want = decode_cell(s_tdata[6:0], s_tuser[0], s_tuser[1]);
            cell_q.push_back(pin_flag ? pin_val : want);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Receiver: random stall patterns, with long hold-offs on request
    always @(negedge i_clk) begin
        if (hold_taken != hold_asked) begin
            hold_taken = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready = 1'b0;
        end else begin
            if (rx_window == 0) begin
                rx_window = $urandom_range(8, 64);
                rx_mode = $urandom_range(0, 3);
                stall_mask = 16'($urandom);
            end
            rx_window--;
            case (rx_mode)
                0: m_tready = 1'b1;
                1: m_tready = 1'($urandom_range(0, 1));
                2: m_tready = stall_mask[rx_tick[3:0]];
                default: m_tready = ($urandom_range(0, 9) != 0);
            endcase
            rx_tick++;
        end
    end

    task automatic add_row(logic [6:0] code, logic first, logic dflt_transp, logic pinned,
                           t_result want);
        t_dir_row row;
        row.code = code;
        row.first = first;
        row.dflt_transp = dflt_transp;
        row.pinned = pinned;
        row.want = want;
        dir_rows.push_back(row);
    endtask

    // Offer one item in bursts; returns at the falling edge after acceptance
    task automatic send_cell(logic [6:0] code, logic first, logic dflt_transp, logic pinned,
                             t_result want);
        if (burst_left == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = {1'b0, code};
        s_tuser = {dflt_transp, first};
        pin_flag = pinned;
        pin_val = want;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic set_reg(logic [1:0] idx, logic v);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        @(posedge i_clk);
        case (idx)
            CFG_MIX_MODE:       cfg_now.mix_mode = v;
            CFG_FLASH_PHASE_ON: cfg_now.flash_phase_on = v;
            CFG_REVEAL:         cfg_now.reveal = v;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        pin_flag = 1'b0;
        while (cell_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        t_cfg settings[8];
        int sent;
        int row_len;
        int col;
        logic broken;
        logic row_transp;
        logic first;
        logic [6:0] ch;
        int pick;

        settings = '{3'b111, 3'b000, 3'b010, 3'b101, 3'b001, 3'b110, 3'b100, 3'b011};

        // directed: row defaults, extremes, every named control code, hold and mosaic cases
        add_row(7'h41, 1'b1, 1'b0, 1'b1, plain_cell(COLOUR_WHITE, COLOUR_BLACK, 7'h41, 1'b1));
        add_row(CODE_SPACE, 1'b0, 1'b0, 1'b1,
                plain_cell(COLOUR_WHITE, COLOUR_BLACK, CODE_SPACE, 1'b0));
        add_row(7'h7f, 1'b0, 1'b1, 1'b1, plain_cell(COLOUR_WHITE, COLOUR_BLACK, 7'h7f, 1'b1));
        add_row(CODE_ALPHA_BLACK, 1'b0, 1'b0, 1'b1,
                plain_cell(CODE_ALPHA_BLACK[2:0], COLOUR_BLACK, CODE_SPACE, 1'b0));
        add_row(CODE_ALPHA_WHITE, 1'b1, 1'b1, 1'b1,
                plain_cell(COLOUR_WHITE, COLOUR_TRANSPARENT, CODE_SPACE, 1'b0));
        add_row(CODE_NEW_BG, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_BLACK_BG, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_START_BOX, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_BLACK_BG, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_END_BOX, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_MOSAIC_WHITE, 1'b0, 1'b0, 1'b0, '0);
        add_row(7'h7f, 1'b0, 1'b0, 1'b0, '0);
        add_row(7'h41, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_SEPARATED, 1'b0, 1'b0, 1'b0, '0);
        add_row(7'h35, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_HOLD, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_UNUSED_0E, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_UNUSED_0F, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_UNUSED_1B, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_CONTIGUOUS, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_ALPHA_WHITE, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_RELEASE, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_FLASH, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_DOUBLE_HEIGHT, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_CONCEAL, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_STEADY, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_NORMAL_SIZE, 1'b0, 1'b0, 1'b0, '0);
        add_row(CODE_MOSAIC_BLACK, 1'b0, 1'b0, 1'b0, '0);

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[i])
            send_cell(dir_rows[i].code, dir_rows[i].first, dir_rows[i].dflt_transp,
                      dir_rows[i].pinned, dir_rows[i].want);

        foreach (settings[p]) begin
            drain();
            set_reg(CFG_MIX_MODE, settings[p].mix_mode);
            set_reg(CFG_FLASH_PHASE_ON, settings[p].flash_phase_on);
            set_reg(CFG_REVEAL, settings[p].reveal);
            // stall the output long enough to back up the input
            if (p == 0 || p == 5) hold_asked++;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                row_len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 8)
                                                      : $urandom_range(20, 40);
                broken = ($urandom_range(0, 19) == 0);
                row_transp = 1'($urandom_range(0, 1));
                for (col = 0; col < row_len; col++) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 35)
                        ch = 7'($urandom_range(0, 31));
                    else if (pick < 65)
                        ch = {1'($urandom_range(0, 1)), 1'b1, 5'($urandom_range(0, 31))};
                    else
                        ch = 7'($urandom_range(0, 127));
                    first = (col == 0 && !broken) || ($urandom_range(0, 49) == 0);
                    send_cell(ch, first, (col == 0) ? row_transp : 1'($urandom_range(0, 1)),
                              1'b0, '0);
                    sent++;
                end
            end
        end

        s_tvalid = 1'b0;
        while (cell_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
src/tard_pkg.sv
src/tard_in_stage.sv
src/tard_decode.sv
src/teletext_row_attribute_decoder.sv
tb/tb_teletext_row_attribute_decoder.sv
